// ----- src/ispc_pkg.sv -----
package ispc_pkg;

    // Field widths fixed by the interface
    localparam int CFG_W            = 20;
    localparam int CFG_INDEX_W      = 4;
    localparam int ISPC_IDLE_BITS_DEF = 20;

    // Register indexes on the configuration channel
    localparam logic [CFG_INDEX_W-1:0] REG_SLEEP_TIMEOUT = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_DEEP_TIMEOUT  = CFG_INDEX_W'(1);

    // Reset values of the timeout registers
    localparam logic [CFG_W-1:0] SLEEP_TIMEOUT_RST = CFG_W'(11000);
    localparam logic [CFG_W-1:0] DEEP_TIMEOUT_RST  = CFG_W'(15000);

    typedef struct packed {
        logic touched;
        logic irq_pending;
        logic vbus_connected;
        logic vbus_removed;
        logic charge_started;
        logic charge_finished;
        logic button_short_press;
    } ispc_item_t;

    typedef struct packed {
        logic is_asleep;
        logic went_to_sleep;
        logic woke_up;
        logic deep_sleep_request;
        logic is_plugged;
        logic is_charging;
    } ispc_result_t;

    typedef struct packed {
        logic asleep;
        logic plugged;
        logic charging;
    } ispc_flags_t;

    typedef struct packed {
        logic [CFG_W-1:0] sleep_timeout_ms;
        logic [CFG_W-1:0] deep_sleep_timeout_ms;
    } ispc_timeouts_t;

endpackage

// ----- src/idle_sleep_power_controller_unit.sv -----
// Idle sleep power controller. Each transfer on the item channel is one
// millisecond tick carrying the touch flag and the power chip interrupt flags;
// each tick yields exactly one transfer on the result channel, in order. The
// block tracks plugged and charging from the interrupts, keeps a saturating
// idle counter (IDLE_BITS wide), toggles sleep on a short key press, wakes on
// touch, powers down an unplugged awake device once idle exceeds
// sleep_timeout_ms, and raises deep_sleep_request while asleep and idle beyond
// deep_sleep_timeout_ms. Rate: one tick per clock cycle sustained while
// result_ready holds. A tick sits in the input register, the update logic
// folds it into the state, and the state and result registers load together
// once the result register is free or draining. The result register lets a
// new tick enter while a finished result waits for result_ready. Timeouts are
// written over the cfg channel (index 0 sleep, index 1 deep sleep), always
// ready; write them only while no tick is in flight.
module idle_sleep_power_controller_unit
    import ispc_pkg::*;
#(
    parameter int IDLE_BITS = ISPC_IDLE_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_ready,
    input  ispc_item_t             item,
    output logic                   result_valid,
    input  logic                   result_ready,
    output ispc_result_t           result,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]       cfg_data
);

    // Input stage
    logic                 stage_valid_reg;
    ispc_item_t           stage_item_reg;

    // Result stage
    logic                 result_valid_reg;
    ispc_result_t         result_reg;
    ispc_result_t         result_next;

    // Tick state
    ispc_flags_t          flags_reg;
    ispc_flags_t          flags_next;
    logic [IDLE_BITS-1:0] idle_reg;
    logic [IDLE_BITS-1:0] idle_next;

    ispc_timeouts_t       timeouts;
    logic                 advance;

    ispc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .timeouts  (timeouts)
    );

    ispc_step #(
        .IDLE_BITS (IDLE_BITS)
    ) u_step (
        .flags      (flags_reg),
        .idle       (idle_reg),
        .item       (stage_item_reg),
        .timeouts   (timeouts),
        .flags_next (flags_next),
        .idle_next  (idle_next),
        .result     (result_next)
    );

    // Advance the held tick when the result register is free or draining
    assign advance      = stage_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready   = !stage_valid_reg || advance;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg  <= 1'b0;
            result_valid_reg <= 1'b0;
            flags_reg        <= '0;
            idle_reg         <= '0;
        end
        else
        begin
            if (item_ready)
            begin
                stage_valid_reg <= item_valid;
            end
            if (advance)
            begin
                result_valid_reg <= 1'b1;
                flags_reg        <= flags_next;
                idle_reg         <= idle_next;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset
    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            stage_item_reg <= item;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

endmodule

// ----- src/ispc_cfg_regs.sv -----
module ispc_cfg_regs
    import ispc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]       cfg_data,
    output ispc_timeouts_t         timeouts
);

    ispc_timeouts_t timeouts_reg;

    assign cfg_ready = 1'b1;
    assign timeouts  = timeouts_reg;

    // Writes to unknown indexes drop silently
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeouts_reg.sleep_timeout_ms      <= SLEEP_TIMEOUT_RST;
            timeouts_reg.deep_sleep_timeout_ms <= DEEP_TIMEOUT_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_SLEEP_TIMEOUT: timeouts_reg.sleep_timeout_ms      <= cfg_data;
                REG_DEEP_TIMEOUT:  timeouts_reg.deep_sleep_timeout_ms <= cfg_data;
                default:           ;
            endcase
        end
    end

endmodule

// ----- src/ispc_step.sv -----
module ispc_step
    import ispc_pkg::*;
#(
    parameter int IDLE_BITS = ISPC_IDLE_BITS_DEF
)
(
    input  ispc_flags_t          flags,
    input  logic [IDLE_BITS-1:0] idle,
    input  ispc_item_t           item,
    input  ispc_timeouts_t       timeouts,
    output ispc_flags_t          flags_next,
    output logic [IDLE_BITS-1:0] idle_next,
    output ispc_result_t         result
);

    localparam int CMP_W = (IDLE_BITS > CFG_W) ? IDLE_BITS : CFG_W;
    localparam logic [IDLE_BITS-1:0] IDLE_MAX = {IDLE_BITS{1'b1}};

    logic [IDLE_BITS-1:0] idle_inc;
    logic [IDLE_BITS-1:0] idle_mid;
    logic                 press;
    logic                 press_wake;
    logic                 entered;
    logic                 asleep_mid;
    logic                 plugged_mid;
    logic                 charging_mid;
    logic                 over_deep;
    logic                 over_sleep;
    logic                 touch_wake;
    logic                 power_down;

    always_comb
    begin
        idle_inc = (idle == IDLE_MAX) ? idle : IDLE_BITS'(idle + 1'b1);

        // Interrupt flags in order: removal beats plug, done beats start
        plugged_mid  = flags.plugged;
        charging_mid = flags.charging;
        if (item.irq_pending)
        begin
            if (item.vbus_connected)  plugged_mid  = 1'b1;
            if (item.vbus_removed)    plugged_mid  = 1'b0;
            if (item.charge_started)  charging_mid = 1'b1;
            if (item.charge_finished) charging_mid = 1'b0;
        end

        press      = item.irq_pending && item.button_short_press;
        press_wake = press && flags.asleep;
        entered    = press && !flags.asleep;
        asleep_mid = flags.asleep ^ press;

        idle_mid = (item.touched || press_wake) ? '0 : idle_inc;

        over_deep  = CMP_W'(idle_mid) > CMP_W'(timeouts.deep_sleep_timeout_ms);
        over_sleep = CMP_W'(idle_mid) > CMP_W'(timeouts.sleep_timeout_ms);

        touch_wake = asleep_mid && item.touched && !entered;
        power_down = !asleep_mid && !plugged_mid && over_sleep;

        flags_next.asleep   = (asleep_mid && !touch_wake) || power_down;
        flags_next.plugged  = plugged_mid;
        flags_next.charging = charging_mid;
        idle_next           = idle_mid;

        result.is_asleep          = flags_next.asleep;
        result.went_to_sleep      = entered || power_down;
        result.woke_up            = press_wake || touch_wake;
        result.deep_sleep_request = asleep_mid && !touch_wake && over_deep;
        result.is_plugged         = plugged_mid;
        result.is_charging        = charging_mid;
    end

endmodule

// ----- src/ispc_checker.sv -----
module ispc_checker
    import ispc_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   item_valid,
    input logic                   item_ready,
    input logic                   result_valid,
    input logic                   result_ready,
    input ispc_result_t           result
);

    // Hold a stalled result
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // Never sleep and wake in the same tick
    a_no_both_pulses: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(result.went_to_sleep && result.woke_up))
        else $error("sleep and wake pulses together");

    // Deep sleep only from the asleep state
    a_deep_needs_sleep: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.deep_sleep_request |-> result.is_asleep)
        else $error("deep sleep request while awake");

    // Pulses agree with the reported state
    a_pulse_state: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (!result.went_to_sleep || result.is_asleep)
                      && (!result.woke_up || !result.is_asleep))
        else $error("pulse disagrees with sleep state");

    // A tick taken while no result is waiting reaches result_valid through the input and result registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && !result_valid |=> ##1 result_valid)
        else $error("result missing after transfer");

endmodule

bind idle_sleep_power_controller_unit ispc_checker u_ispc_checker (.*);
